/* sv/edf_pkg.sv */
package edf_pkg;

	localparam int TIME_W        = 32;
	localparam int FIELD_W       = 16;
	localparam int SLOT_W        = 3;
	localparam int NOW_CNT_W     = 4;
	localparam int MAX_TASKS_DEF = 8;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_SCAN,
		ST_RUN,
		ST_OUT
	} edf_state_t;

	typedef struct packed {
		logic [FIELD_W-1:0] period;
		logic [FIELD_W-1:0] window;
		logic [FIELD_W-1:0] exec;
		logic [TIME_W-1:0]  next_rel;
		logic [TIME_W-1:0]  deadline;
		logic [FIELD_W-1:0] remaining;
	} slot_rec_t;

	typedef struct packed {
		logic              rel;
		logic              rel_miss;
		logic              drop;
		logic              pend;
		logic              better;
		logic [TIME_W-1:0] key;
		slot_rec_t         rec_new;
	} slot_eval_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] v,
		input logic [1:0] inc);
		logic [TIME_W:0] s;
		s = {1'b0, v} + {{(TIME_W - 1){1'b0}}, inc};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

/* sv/edf_rem.sv */
module edf_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [edf_pkg::TIME_W-1:0]    dividend,
	input  logic [edf_pkg::FIELD_W-1:0]   divisor,
	output logic                          done,
	output logic [edf_pkg::FIELD_W-1:0]   rem
);
	import edf_pkg::*;

	localparam int STEP_W = $clog2(TIME_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [TIME_W-1:0]   dvd_q;
	logic [FIELD_W-1:0]  dsr_q;
	logic [FIELD_W-1:0]  rem_q;
	logic [FIELD_W:0]    trial;
	logic [FIELD_W-1:0]  rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[TIME_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_nxt = FIELD_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_nxt = trial[FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* sv/edf_slot_eval.sv */
module edf_slot_eval (
	input  edf_pkg::slot_rec_t          rec,
	input  logic                        active,
	input  logic                        pending,
	input  logic [edf_pkg::TIME_W-1:0]  now,
	input  logic                        best_found,
	input  logic [edf_pkg::TIME_W-1:0]  best_key,
	output edf_pkg::slot_eval_t         ev
);
	import edf_pkg::*;

	logic               rel;
	logic               live;
	logic [TIME_W-1:0]  dl;
	logic [TIME_W-1:0]  key;
	logic [FIELD_W-1:0] rem;

	always_comb begin
		rel  = active && (rec.next_rel == now);
		live = rel || pending;
		dl   = rel ? now + TIME_W'(rec.window) : rec.deadline;
		rem  = rel ? rec.exec : rec.remaining;
		key  = dl - now;

		ev.rel      = rel;
		ev.rel_miss = rel && pending;
		// negative laxity: deadline already behind now, or too close for what is left
		ev.drop     = live && (key[TIME_W-1] || (key < TIME_W'(rem)));
		ev.pend     = live && !ev.drop;
		ev.better   = ev.pend && (!best_found || (key < best_key));
		ev.key      = key;

		ev.rec_new           = rec;
		ev.rec_new.next_rel  = rel ? now + TIME_W'(rec.period) : rec.next_rel;
		ev.rec_new.deadline  = dl;
		ev.rec_new.remaining = rem;
	end

endmodule

/* sv/edf_task_scheduler.sv */
// EDF task scheduler.
// Input channel (in_valid/in_ready) takes one word per command: cmd=1 loads
// task_slot with phase, period, relative deadline and execution time;
// cmd=0 advances one tick (release, drop negative laxity, run earliest
// deadline job, advance time). Every input word yields one output word on
// the out_valid/out_ready channel.
// A tick walks the slot table one entry per cycle through a single
// evaluation unit, then updates the chosen job and advances time, and the
// result word is registered for output. A load whose phase is already past
// first runs the 32-step remainder unit to find its next release.
// Only one word is processed at a time; in_ready is low while it is.
// The output register holds a finished word while the next one is
// processed; if out_ready stays low the block waits in its last step with
// in_ready low until the word is taken.
// Reset clears time, active and pending flags and the totals; the slot
// table itself is not cleared and is written by loads.
module edf_task_scheduler #(
	parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [edf_pkg::SLOT_W-1:0]        task_slot,
	input  logic                              task_enable,
	input  logic [edf_pkg::FIELD_W-1:0]       task_phase,
	input  logic [edf_pkg::FIELD_W-1:0]       task_period,
	input  logic [edf_pkg::FIELD_W-1:0]       task_rel_deadline,
	input  logic [edf_pkg::FIELD_W-1:0]       task_exec_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [edf_pkg::TIME_W-1:0]        tick_time,
	output logic                              ran_job,
	output logic [edf_pkg::SLOT_W-1:0]        running_slot,
	output logic                              job_done,
	output logic [edf_pkg::NOW_CNT_W-1:0]     released_now,
	output logic [edf_pkg::NOW_CNT_W-1:0]     missed_now,
	output logic [edf_pkg::TIME_W-1:0]        total_released,
	output logic [edf_pkg::TIME_W-1:0]        total_missed
);
	import edf_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	edf_state_t state_q, state_nxt;

	logic                 in_acc;
	logic                 ld_ok;
	logic [FIELD_W-1:0]   per_eff;
	logic                 out_free;

	logic [TIME_W-1:0]    now_q;
	logic [MAX_TASKS-1:0] active_q;
	logic [MAX_TASKS-1:0] pending_q;
	logic [TIME_W-1:0]    released_total_q;
	logic [TIME_W-1:0]    missed_total_q;

	logic [CNT_W-1:0]     rd_cnt_q;
	logic                 proc_v_s1;
	logic [IDX_W-1:0]     proc_idx_s1;
	logic [CNT_W-1:0]     rel_cnt_q;
	logic [CNT_W:0]       miss_cnt_q;
	logic                 best_found_q;
	logic [TIME_W-1:0]    best_key_q;
	logic [IDX_W-1:0]     best_idx_q;
	slot_rec_t            best_rec_q;
	logic                 run_done;

	logic [IDX_W-1:0]     ld_idx_q;
	logic                 ld_en_q;
	logic [FIELD_W-1:0]   ld_per_q;
	logic [FIELD_W-1:0]   ld_win_q;
	logic [FIELD_W-1:0]   ld_exec_q;
	logic [TIME_W-1:0]    ld_next_q;

	logic                 div_start;
	logic                 div_done;
	logic [FIELD_W-1:0]   div_rem;

	slot_rec_t            slot_mem [MAX_TASKS];
	slot_rec_t            rd_data_q;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	slot_rec_t            mem_wdata;
	slot_rec_t            run_rec;
	slot_rec_t            ld_rec;

	slot_eval_t           ev;
	logic [1:0]           miss_inc;

	logic [TIME_W-1:0]    res_time_q;
	logic                 res_ran_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic                 res_done_q;
	logic [NOW_CNT_W-1:0] res_rel_q;
	logic [NOW_CNT_W-1:0] res_miss_q;

	logic                 out_valid_q;
	logic [TIME_W-1:0]    tick_time_q;
	logic                 ran_job_q;
	logic [SLOT_W-1:0]    running_slot_q;
	logic                 job_done_q;
	logic [NOW_CNT_W-1:0] released_now_q;
	logic [NOW_CNT_W-1:0] missed_now_q;
	logic [TIME_W-1:0]    total_released_q;
	logic [TIME_W-1:0]    total_missed_q;

	edf_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (now_q - TIME_W'(task_phase)),
		.divisor  (per_eff),
		.done     (div_done),
		.rem      (div_rem)
	);

	edf_slot_eval u_eval (
		.rec        (rd_data_q),
		.active     (active_q[proc_idx_s1]),
		.pending    (pending_q[proc_idx_s1]),
		.now        (now_q),
		.best_found (best_found_q),
		.best_key   (best_key_q),
		.ev         (ev)
	);

	assign in_acc   = in_valid && in_ready;
	assign ld_ok    = 32'(task_slot) < MAX_TASKS;
	assign per_eff  = (task_period == '0) ? FIELD_W'(1) : task_period;
	assign out_free = !out_valid_q || out_ready;
	assign miss_inc = {1'b0, ev.rel_miss} + {1'b0, ev.drop};
	assign run_done = best_rec_q.remaining <= FIELD_W'(1);

	always_comb begin
		run_rec = best_rec_q;
		run_rec.remaining = run_done ? '0 : best_rec_q.remaining - 1'b1;
		ld_rec = '0;
		ld_rec.period   = ld_per_q;
		ld_rec.window   = ld_win_q;
		ld_rec.exec     = ld_exec_q;
		ld_rec.next_rel = ld_next_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ld_idx_q;
		mem_wdata = ld_rec;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_TICK) begin
						state_nxt = ST_SCAN;
					end else if (!ld_ok) begin
						state_nxt = ST_OUT;
					end else if (TIME_W'(task_phase) >= now_q) begin
						state_nxt = ST_LOAD;
					end else begin
						div_start = 1'b1;
						state_nxt = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				mem_we    = 1'b1;
				state_nxt = ST_OUT;
			end
			ST_SCAN: begin
				mem_we    = proc_v_s1;
				mem_waddr = proc_idx_s1;
				mem_wdata = ev.rec_new;
				if (proc_v_s1 && (rd_cnt_q == CNT_W'(MAX_TASKS))) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				mem_we    = best_found_q;
				mem_waddr = best_idx_q;
				mem_wdata = run_rec;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= slot_mem[rd_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q            <= '0;
			active_q         <= '0;
			pending_q        <= '0;
			released_total_q <= '0;
			missed_total_q   <= '0;
			rd_cnt_q         <= '0;
			proc_v_s1        <= 1'b0;
			rel_cnt_q        <= '0;
			miss_cnt_q       <= '0;
			best_found_q     <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && cmd == CMD_TICK) begin
						rd_cnt_q     <= '0;
						proc_v_s1    <= 1'b0;
						rel_cnt_q    <= '0;
						miss_cnt_q   <= '0;
						best_found_q <= 1'b0;
					end
				end
				ST_LOAD: begin
					active_q[ld_idx_q]  <= ld_en_q;
					pending_q[ld_idx_q] <= 1'b0;
				end
				ST_SCAN: begin
					if (rd_cnt_q != CNT_W'(MAX_TASKS)) begin
						rd_cnt_q  <= rd_cnt_q + 1'b1;
						proc_v_s1 <= 1'b1;
					end else begin
						proc_v_s1 <= 1'b0;
					end
					if (proc_v_s1) begin
						pending_q[proc_idx_s1] <= ev.pend;
						rel_cnt_q        <= rel_cnt_q + CNT_W'(ev.rel);
						miss_cnt_q       <= miss_cnt_q + (CNT_W + 1)'(miss_inc);
						released_total_q <= sat_add(released_total_q, {1'b0, ev.rel});
						missed_total_q   <= sat_add(missed_total_q, miss_inc);
						if (ev.better) begin
							best_found_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (best_found_q && run_done) begin
						pending_q[best_idx_q] <= 1'b0;
					end
					now_q <= now_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_LOAD) begin
					ld_idx_q   <= IDX_W'(task_slot);
					ld_en_q    <= task_enable;
					ld_per_q   <= per_eff;
					ld_win_q   <= (task_rel_deadline < per_eff) ? task_rel_deadline : per_eff;
					ld_exec_q  <= task_exec_time;
					ld_next_q  <= TIME_W'(task_phase);
					res_time_q <= '0;
					res_ran_q  <= 1'b0;
					res_slot_q <= '0;
					res_done_q <= 1'b0;
					res_rel_q  <= '0;
					res_miss_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ld_next_q <= (div_rem == '0) ? now_q :
						now_q + TIME_W'(ld_per_q - div_rem);
				end
			end
			ST_SCAN: begin
				proc_idx_s1 <= rd_cnt_q[IDX_W-1:0];
				if (proc_v_s1 && ev.better) begin
					best_key_q <= ev.key;
					best_idx_q <= proc_idx_s1;
					best_rec_q <= ev.rec_new;
				end
			end
			ST_RUN: begin
				res_time_q <= now_q;
				res_ran_q  <= best_found_q;
				res_slot_q <= best_found_q ? SLOT_W'(best_idx_q) : '0;
				res_done_q <= best_found_q && run_done;
				res_rel_q  <= (32'(rel_cnt_q) > 32'd15) ? 4'hF : NOW_CNT_W'(rel_cnt_q);
				res_miss_q <= (32'(miss_cnt_q) > 32'd15) ? 4'hF : NOW_CNT_W'(miss_cnt_q);
			end
			ST_OUT: begin
				if (out_free) begin
					tick_time_q      <= res_time_q;
					ran_job_q        <= res_ran_q;
					running_slot_q   <= res_slot_q;
					job_done_q       <= res_done_q;
					released_now_q   <= res_rel_q;
					missed_now_q     <= res_miss_q;
					total_released_q <= released_total_q;
					total_missed_q   <= missed_total_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign tick_time      = tick_time_q;
	assign ran_job        = ran_job_q;
	assign running_slot   = running_slot_q;
	assign job_done       = job_done_q;
	assign released_now   = released_now_q;
	assign missed_now     = missed_now_q;
	assign total_released = total_released_q;
	assign total_missed   = total_missed_q;

	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == CMD_TICK) |=> (state_q == ST_SCAN))
		else $error("tick word did not start a slot scan");

	a_done_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && job_done) |-> ran_job)
		else $error("job_done without ran_job");

	a_idle_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ran_job) |-> (running_slot == '0 && !job_done))
		else $error("running_slot set with no job run");

	a_miss_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (missed_total_q >= $past(missed_total_q)))
		else $error("missed total went backward");

endmodule

/* verif/edf_task_scheduler_tb.sv */
module edf_task_scheduler_tb;
	import edf_pkg::*;

	localparam int NSLOT = MAX_TASKS_DEF;
	localparam int GAP_MAX = 18;
	localparam int DRAIN_CYCLES = NSLOT + 8;

	typedef struct {
		logic               cmd;
		logic [SLOT_W-1:0]  slot;
		logic               en;
		logic [FIELD_W-1:0] phase;
		logic [FIELD_W-1:0] period;
		logic [FIELD_W-1:0] deadline;
		logic [FIELD_W-1:0] exec;
	} sched_word_t;

	typedef struct {
		logic [TIME_W-1:0]    tick_time;
		logic                 ran;
		logic [SLOT_W-1:0]    run_slot;
		logic                 done;
		logic [NOW_CNT_W-1:0] rel_now;
		logic [NOW_CNT_W-1:0] miss_now;
		logic [TIME_W-1:0]    tot_rel;
		logic [TIME_W-1:0]    tot_miss;
	} sched_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	logic [SLOT_W-1:0]    task_slot;
	logic                 task_enable;
	logic [FIELD_W-1:0]   task_phase;
	logic [FIELD_W-1:0]   task_period;
	logic [FIELD_W-1:0]   task_rel_deadline;
	logic [FIELD_W-1:0]   task_exec_time;
	logic                 out_valid;
	logic                 out_ready;
	logic [TIME_W-1:0]    tick_time;
	logic                 ran_job;
	logic [SLOT_W-1:0]    running_slot;
	logic                 job_done;
	logic [NOW_CNT_W-1:0] released_now;
	logic [NOW_CNT_W-1:0] missed_now;
	logic [TIME_W-1:0]    total_released;
	logic [TIME_W-1:0]    total_missed;

	// scheduler mirror
	logic [31:0] sch_now;
	logic        sch_active [NSLOT];
	logic [31:0] sch_period [NSLOT];
	logic [31:0] sch_window [NSLOT];
	logic [31:0] sch_exec [NSLOT];
	logic [31:0] sch_next_rel [NSLOT];
	logic        sch_pending [NSLOT];
	logic [31:0] sch_deadline [NSLOT];
	logic [31:0] sch_remaining [NSLOT];
	logic [31:0] sch_rel_total;
	logic [31:0] sch_miss_total;

	sched_result_t sched_expect_q [$];
	int n_errors;
	int n_checked;
	int n_loads;
	int n_ticks;
	int n_runs;
	bit no_idle;

	edf_task_scheduler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.task_slot(task_slot),
		.task_enable(task_enable),
		.task_phase(task_phase),
		.task_period(task_period),
		.task_rel_deadline(task_rel_deadline),
		.task_exec_time(task_exec_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tick_time(tick_time),
		.ran_job(ran_job),
		.running_slot(running_slot),
		.job_done(job_done),
		.released_now(released_now),
		.missed_now(missed_now),
		.total_released(total_released),
		.total_missed(total_missed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic sched_result_t edf_predict(input sched_word_t w);
		sched_result_t r;
		logic [31:0] per;
		logic [31:0] rem;
		logic [31:0] dl_gap;
		logic [31:0] best_key;
		longint lax;
		bit found;
		int best;
		int rel_cnt;
		int miss_cnt;
		r.tick_time = '0;
		r.ran = 1'b0;
		r.run_slot = '0;
		r.done = 1'b0;
		rel_cnt = 0;
		miss_cnt = 0;
		if (w.cmd == CMD_LOAD) begin
			per = (w.period == 16'd0) ? 32'd1 : {16'd0, w.period};
			sch_active[w.slot] = w.en;
			sch_period[w.slot] = per;
			sch_window[w.slot] = ({16'd0, w.deadline} < per) ? {16'd0, w.deadline} : per;
			sch_exec[w.slot] = {16'd0, w.exec};
			sch_pending[w.slot] = 1'b0;
			if ({16'd0, w.phase} >= sch_now) begin
				sch_next_rel[w.slot] = {16'd0, w.phase};
			end else begin
				rem = (sch_now - {16'd0, w.phase}) % per;
				sch_next_rel[w.slot] = sch_now + ((rem != 0) ? per - rem : 32'd0);
			end
		end else begin
			r.tick_time = sch_now;
			for (int s = 0; s < NSLOT; s++) begin
				if (sch_active[s] && sch_next_rel[s] == sch_now) begin
					if (sch_pending[s]) begin
						miss_cnt++;
						sch_miss_total = sat_inc32(sch_miss_total);
					end
					sch_pending[s] = 1'b1;
					sch_deadline[s] = sch_now + sch_window[s];
					sch_remaining[s] = sch_exec[s];
					sch_next_rel[s] = sch_now + sch_period[s];
					rel_cnt++;
					sch_rel_total = sat_inc32(sch_rel_total);
				end
			end
			for (int s = 0; s < NSLOT; s++) begin
				if (sch_pending[s]) begin
					dl_gap = sch_deadline[s] - sch_now;
					lax = longint'($signed(dl_gap)) - longint'(sch_remaining[s]);
					if (lax < 0) begin
						sch_pending[s] = 1'b0;
						miss_cnt++;
						sch_miss_total = sat_inc32(sch_miss_total);
					end
				end
			end
			found = 1'b0;
			best = 0;
			best_key = '0;
			for (int s = 0; s < NSLOT; s++) begin
				if (sch_pending[s]) begin
					dl_gap = sch_deadline[s] - sch_now;
					if (!found || dl_gap < best_key) begin
						found = 1'b1;
						best_key = dl_gap;
						best = s;
					end
				end
			end
			if (found) begin
				r.ran = 1'b1;
				r.run_slot = SLOT_W'(best);
				n_runs++;
				if (sch_remaining[best] <= 32'd1) begin
					sch_remaining[best] = '0;
					sch_pending[best] = 1'b0;
					r.done = 1'b1;
				end else begin
					sch_remaining[best] = sch_remaining[best] - 32'd1;
				end
			end
			sch_now = sch_now + 32'd1;
		end
		r.rel_now = NOW_CNT_W'((rel_cnt > 15) ? 15 : rel_cnt);
		r.miss_now = NOW_CNT_W'((miss_cnt > 15) ? 15 : miss_cnt);
		r.tot_rel = sch_rel_total;
		r.tot_miss = sch_miss_total;
		return r;
	endfunction

	function automatic sched_word_t tick_word();
		sched_word_t w;
		w.cmd = CMD_TICK;
		w.slot = '0;
		w.en = 1'b0;
		w.phase = '0;
		w.period = '0;
		w.deadline = '0;
		w.exec = '0;
		return w;
	endfunction

	function automatic sched_word_t load_word(input int slot, input bit en, input int ph,
		input int per, input int dl, input int ex);
		sched_word_t w;
		w.cmd = CMD_LOAD;
		w.slot = SLOT_W'(slot);
		w.en = en;
		w.phase = FIELD_W'(ph);
		w.period = FIELD_W'(per);
		w.deadline = FIELD_W'(dl);
		w.exec = FIELD_W'(ex);
		return w;
	endfunction

	// mostly small task sets that keep the table busy; some full-range noise
	function automatic sched_word_t random_word();
		sched_word_t w;
		int per;
		w = tick_word();
		if ($urandom_range(0, 99) < 15) begin
			w.cmd = CMD_LOAD;
			w.slot = SLOT_W'($urandom_range(0, NSLOT - 1));
			w.en = ($urandom_range(0, 7) != 0);
			if ($urandom_range(0, 7) == 0) begin
				w.phase = FIELD_W'($urandom_range(0, 65535));
				w.period = FIELD_W'($urandom_range(0, 65535));
				w.deadline = FIELD_W'($urandom_range(0, 65535));
				w.exec = FIELD_W'($urandom_range(0, 65535));
			end else begin
				per = $urandom_range(0, 24);
				w.period = FIELD_W'(per);
				w.deadline = FIELD_W'($urandom_range(0, per + 3));
				w.exec = FIELD_W'($urandom_range(0, (per < 4) ? 2 : per / 2));
				w.phase = FIELD_W'($urandom_range(0, sch_now + 30));
			end
		end
		return w;
	endfunction

	task automatic send_word(input sched_word_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = w.cmd;
		task_slot = w.slot;
		task_enable = w.en;
		task_phase = w.phase;
		task_period = w.period;
		task_rel_deadline = w.deadline;
		task_exec_time = w.exec;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sched_expect_q.insert(sched_expect_q.size(), edf_predict(w));
		if (w.cmd == CMD_LOAD)
			n_loads++;
		else
			n_ticks++;
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(tick_word());
	endtask

	task automatic test_idle_tick();
		send_ticks(1);
	endtask

	task automatic test_priority_and_extremes();
		send_word(load_word(0, 1'b1, 0, 5, 5, 2));
		send_word(load_word(3, 1'b1, 0, 5, 5, 2));
		send_word(load_word(7, 1'b1, 0, 65535, 65535, 65535));
		send_ticks(4);
	endtask

	task automatic test_zero_fields();
		send_word(load_word(1, 1'b1, 0, 0, 0, 0));
		send_word(load_word(6, 1'b1, sch_now + 1, 4, 4, 0));
		send_ticks(3);
	endtask

	task automatic test_overrun_and_replace();
		send_word(load_word(2, 1'b1, 0, 1, 1, 1));
		send_word(load_word(4, 1'b1, 0, 2, 2, 1));
		send_word(load_word(5, 1'b1, 0, 9, 3, 7));
		send_ticks(4);
	endtask

	task automatic test_past_phase_and_disable();
		send_word(load_word(5, 1'b1, 3, 7, 7, 1));
		send_word(load_word(1, 1'b0, 0, 1, 1, 1));
		send_word(load_word(0, 1'b1, 65535, 65535, 40000, 32768));
		send_ticks(2);
	endtask

	task automatic test_random_mix();
		repeat (600) send_word(random_word());
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (40) send_word(random_word());
		no_idle = 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [31:0] expv,
		input logic [31:0] actv);
		if (actv !== expv) begin
			n_errors++;
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, expv, actv);
		end
	endfunction

	always @(posedge clk) begin : result_check
		sched_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (sched_expect_q.size() == 0) begin
				n_errors++;
				$display("%0t unexpected word: expected none actual tick_time %0h",
					$time, tick_time);
			end else begin
				exp_r = sched_expect_q.pop_front();
				n_checked++;
				check_field("tick_time", exp_r.tick_time, tick_time);
				check_field("ran_job", 32'(exp_r.ran), 32'(ran_job));
				check_field("running_slot", 32'(exp_r.run_slot), 32'(running_slot));
				check_field("job_done", 32'(exp_r.done), 32'(job_done));
				check_field("released_now", 32'(exp_r.rel_now), 32'(released_now));
				check_field("missed_now", 32'(exp_r.miss_now), 32'(missed_now));
				check_field("total_released", exp_r.tot_rel, total_released);
				check_field("total_missed", exp_r.tot_miss, total_missed);
			end
		end
	end

	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		task_slot = '0;
		task_enable = 1'b0;
		task_phase = '0;
		task_period = '0;
		task_rel_deadline = '0;
		task_exec_time = '0;
		no_idle = 1'b0;
		n_errors = 0;
		n_checked = 0;
		n_loads = 0;
		n_ticks = 0;
		n_runs = 0;
		sch_now = '0;
		sch_rel_total = '0;
		sch_miss_total = '0;
		for (int s = 0; s < NSLOT; s++) begin
			sch_active[s] = 1'b0;
			sch_pending[s] = 1'b0;
			sch_period[s] = '0;
			sch_window[s] = '0;
			sch_exec[s] = '0;
			sch_next_rel[s] = '0;
			sch_deadline[s] = '0;
			sch_remaining[s] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_tick();
		test_priority_and_extremes();
		test_zero_fields();
		test_overrun_and_replace();
		test_past_phase_and_disable();
		test_random_mix();
		test_back_to_back();
		in_valid = 1'b0;

		while (sched_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d loads and %0d ticks, checked %0d result words.",
			n_loads, n_ticks, n_checked);
		$display("Jobs ran on %0d ticks; %0d released, %0d dropped as missed.",
			n_runs, sch_rel_total, sch_miss_total);
		if (n_errors == 0 && sched_expect_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
